/* sv/blind_motor_travel_controller_macros.svh */
// assertion macros shared by the blind motor travel controller rtl
`ifndef BLIND_MOTOR_TRAVEL_CONTROLLER_MACROS_SVH
`define BLIND_MOTOR_TRAVEL_CONTROLLER_MACROS_SVH

// property checked at every clock edge outside reset
`define BMTC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition in one cycle implies a result in the next
`define BMTC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/bmtc_pkg.sv */
// types and constants of the blind motor travel controller
package bmtc_pkg;

   typedef enum logic [2:0] {
      ST_STOP       = 3'd0,
      ST_PAUSED     = 3'd1,
      ST_START_DOWN = 3'd2,
      ST_GOING_DOWN = 3'd3,
      ST_CLOSED     = 3'd4,
      ST_START_UP   = 3'd5,
      ST_GOING_UP   = 3'd6,
      ST_OPEN       = 3'd7
   } motion_type;

   typedef enum logic [2:0] {
      RS_STOP   = 3'd0,
      RS_DOWN   = 3'd1,
      RS_UP     = 3'd2,
      RS_CLOSED = 3'd3,
      RS_OPEN   = 3'd4
   } remote_type;

   typedef enum logic [1:0] {
      CSR_TRAVEL_TIME = 2'd0,
      CSR_INVERT_DIR  = 2'd1,
      CSR_MODBUS      = 2'd2
   } csr_index_type;

   localparam int unsigned TimeWidth = 16;
   localparam logic [TimeWidth-1:0] TimeMax = '1;
   localparam logic [TimeWidth-1:0] TravelTimeReset = 16'd30;

   typedef struct packed {
      logic [TimeWidth-1:0] travel_time_sec;
      logic                 invert_direction;
      logic                 modbus_enabled;
   } cfg_type;

   typedef struct packed {
      logic       up_button;
      logic       down_button;
      logic       second_tick;
      logic [2:0] remote_state;
   } item_type;

   typedef struct packed {
      motion_type           control_state;
      logic [2:0]           reported_status;
      logic                 first_step;
      logic                 up_prev;
      logic                 down_prev;
      logic [TimeWidth-1:0] elapsed;
      logic                 relay_common;
      logic                 relay_direction;
   } state_type;

   typedef struct packed {
      logic       relay_common;
      logic       relay_direction;
      motion_type motion_state;
      logic       report_write;
      logic [2:0] report_value;
   } result_type;

endpackage

/* sv/bmtc_step.sv */
// next state and result of one poll beat
module bmtc_step (
   input  bmtc_pkg::cfg_type    cfg,
   input  bmtc_pkg::item_type   item,
   input  bmtc_pkg::state_type  cur,
   output bmtc_pkg::state_type  nxt,
   output bmtc_pkg::result_type res
);
   import bmtc_pkg::*;

   logic                 up_rise;
   logic                 down_rise;
   logic                 differs;
   logic                 r_down;
   logic                 r_up;
   logic                 r_stop;
   logic                 stop_req;
   logic [TimeWidth-1:0] elapsed_inc;
   logic                 timed_out;
   logic                 wr;
   logic [2:0]           wval;

   assign up_rise      = item.up_button & ~cur.up_prev;
   assign down_rise    = item.down_button & ~cur.down_prev;
   assign differs      = cur.reported_status != item.remote_state;
   assign r_down       = differs && (item.remote_state == RS_DOWN);
   assign r_up         = differs && (item.remote_state == RS_UP);
   assign r_stop       = differs && (item.remote_state == RS_STOP);
   assign stop_req     = down_rise | up_rise | r_stop;
   assign elapsed_inc  = (item.second_tick && cur.elapsed != TimeMax) ?
                         cur.elapsed + TimeWidth'(1) : cur.elapsed;
   assign timed_out    = elapsed_inc >= cfg.travel_time_sec;

   always_comb begin
      nxt            = cur;
      nxt.elapsed    = elapsed_inc;
      nxt.first_step = 1'b0;
      nxt.up_prev    = item.up_button;
      nxt.down_prev  = item.down_button;
      wr             = cur.first_step;
      wval           = cur.reported_status;
      case (cur.control_state)
         ST_STOP: begin
            nxt.relay_common    = 1'b0;
            nxt.relay_direction = 1'b0;
            nxt.reported_status = RS_STOP;
            wr                  = 1'b1;
            wval                = RS_STOP;
            nxt.control_state   = ST_PAUSED;
         end
         ST_PAUSED: begin
            if (down_rise) begin
               nxt.control_state   = ST_START_DOWN;
               nxt.reported_status = RS_DOWN;
               wr                  = 1'b1;
               wval                = RS_DOWN;
            end
            if (up_rise) begin
               nxt.control_state   = ST_START_UP;
               nxt.reported_status = RS_UP;
               wr                  = 1'b1;
               wval                = RS_UP;
            end
            // remote start overrides the state but not the write-back value
            if (!cfg.modbus_enabled) begin
               if (r_down) begin
                  nxt.control_state   = ST_START_DOWN;
                  nxt.reported_status = RS_DOWN;
               end
               if (r_up) begin
                  nxt.control_state   = ST_START_UP;
                  nxt.reported_status = RS_UP;
               end
            end
         end
         ST_START_DOWN: begin
            nxt.relay_common    = 1'b1;
            nxt.relay_direction = ~cfg.invert_direction;
            nxt.elapsed         = '0;
            nxt.reported_status = RS_DOWN;
            if (!cfg.modbus_enabled) begin
               wr   = 1'b1;
               wval = RS_DOWN;
            end
            nxt.control_state = ST_GOING_DOWN;
         end
         ST_GOING_DOWN: begin
            if (stop_req) nxt.control_state = ST_STOP;
            if (timed_out) begin
               nxt.relay_common    = 1'b0;
               nxt.relay_direction = 1'b0;
               nxt.reported_status = RS_CLOSED;
               wr                  = 1'b1;
               wval                = RS_CLOSED;
               nxt.control_state   = ST_CLOSED;
            end
         end
         ST_CLOSED: begin
            if (up_rise || r_up) nxt.control_state = ST_START_UP;
         end
         ST_START_UP: begin
            nxt.relay_common    = 1'b1;
            nxt.relay_direction = cfg.invert_direction;
            nxt.elapsed         = '0;
            nxt.reported_status = RS_UP;
            if (!cfg.modbus_enabled) begin
               wr   = 1'b1;
               wval = RS_UP;
            end
            nxt.control_state = ST_GOING_UP;
         end
         ST_GOING_UP: begin
            if (stop_req) nxt.control_state = ST_STOP;
            if (timed_out) begin
               nxt.relay_common    = 1'b0;
               nxt.relay_direction = 1'b0;
               nxt.reported_status = RS_OPEN;
               wr                  = 1'b1;
               wval                = RS_OPEN;
               nxt.control_state   = ST_OPEN;
            end
         end
         ST_OPEN: begin
            if (down_rise || r_down) nxt.control_state = ST_START_DOWN;
         end
         default: begin
            nxt.control_state = ST_STOP;
         end
      endcase
   end

   always_comb begin
      res.relay_common    = nxt.relay_common;
      res.relay_direction = nxt.relay_direction;
      res.motion_state    = nxt.control_state;
      res.report_write    = wr;
      res.report_value    = wr ? wval : 3'd0;
   end

endmodule

/* sv/blind_motor_travel_controller.sv */
// top level of the blind motor travel controller
//
//  port group  direction  beat contents
//  req_*       in         button levels, second tick, remote state
//  rsp_*       out        relay levels, motion state, status write-back
//  csr_*       in         travel time, direction invert, modbus mode
//
// one poll beat per clock while rsp_stall is low; the poll beat is registered, then the
// step logic updates the controller state and the result register in the same cycle;
// rsp_valid rises from the result register, after the input register has held the beat
// reset is synchronous: state returns to stop, registers to 30 s, no invert, no modbus
// a stalled rsp holds the result and the held poll beat; req_stall rises only then
module blind_motor_travel_controller (
   input  logic        clock,
   input  logic        reset,
   // poll beat in
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_up_button,
   input  logic        req_down_button,
   input  logic        req_second_tick,
   input  logic [2:0]  req_remote_state,
   // result beat out
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_relay_common,
   output logic        rsp_relay_direction,
   output logic [2:0]  rsp_motion_state,
   output logic        rsp_report_write,
   output logic [2:0]  rsp_report_value,
   // register writes
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import bmtc_pkg::*;

`include "blind_motor_travel_controller_macros.svh"

   // configuration registers
   cfg_type    cfg_ff, cfg_in;

   // input stage
   logic       in_valid_ff, in_valid_in;
   item_type   item_ff, item_in;

   // controller state
   state_type  state_ff, state_in;
   state_type  state_next;

   // result stage
   logic       out_valid_ff, out_valid_in;
   result_type result_ff, result_in;
   result_type step_result;

   logic       req_take;
   logic       rsp_take;
   logic       advance;

   // result register properties
   logic       dir_ok;
   logic       zero_ok;
   logic       going_ok;
   logic       rest_ok;

   assign rsp_take  = out_valid_ff & ~rsp_stall;
   // the held beat moves on when the result register is free or being drained
   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   bmtc_step u_step (
      .cfg  (cfg_ff),
      .item (item_ff),
      .cur  (state_ff),
      .nxt  (state_next),
      .res  (step_result)
   );

   // register writes; the host must issue them only while idle, the block does not enforce this
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_TRAVEL_TIME: cfg_in.travel_time_sec  = csr_data[TimeWidth-1:0];
            CSR_INVERT_DIR:  cfg_in.invert_direction = csr_data[0];
            CSR_MODBUS:      cfg_in.modbus_enabled   = csr_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = (in_valid_ff & ~advance) | req_take;
      item_in     = item_ff;
      if (req_take) begin
         item_in.up_button    = req_up_button;
         item_in.down_button  = req_down_button;
         item_in.second_tick  = req_second_tick;
         item_in.remote_state = req_remote_state;
      end
   end

   always_comb begin
      state_in     = advance ? state_next : state_ff;
      out_valid_in = advance | (out_valid_ff & ~rsp_take);
      result_in    = advance ? step_result : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.travel_time_sec  <= TravelTimeReset;
         cfg_ff.invert_direction <= 1'b0;
         cfg_ff.modbus_enabled   <= 1'b0;
         in_valid_ff             <= 1'b0;
         out_valid_ff            <= 1'b0;
         state_ff.control_state   <= ST_STOP;
         state_ff.reported_status <= RS_STOP;
         state_ff.first_step      <= 1'b1;
         state_ff.up_prev         <= 1'b0;
         state_ff.down_prev       <= 1'b0;
         state_ff.elapsed         <= '0;
         state_ff.relay_common    <= 1'b0;
         state_ff.relay_direction <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_relay_common    = result_ff.relay_common;
   assign rsp_relay_direction = result_ff.relay_direction;
   assign rsp_motion_state    = result_ff.motion_state;
   assign rsp_report_write    = result_ff.report_write;
   assign rsp_report_value    = result_ff.report_value;

   assign dir_ok   = !result_ff.relay_direction || result_ff.relay_common;
   assign zero_ok  = result_ff.report_write || result_ff.report_value == 3'd0;
   assign going_ok = !(result_ff.motion_state == ST_GOING_DOWN ||
                       result_ff.motion_state == ST_GOING_UP) || result_ff.relay_common;
   assign rest_ok  = !(result_ff.motion_state == ST_PAUSED ||
                       result_ff.motion_state == ST_CLOSED ||
                       result_ff.motion_state == ST_OPEN) || !result_ff.relay_common;

   // direction relay is only driven while the motor is powered
   `BMTC_ASSERT(a_dir_needs_power, !out_valid_ff || dir_ok, "direction relay without power")
   // no write-back means a zero status value
   `BMTC_ASSERT(a_report_zero, !out_valid_ff || zero_ok, "report value set without write")
   // moving states keep the motor powered
   `BMTC_ASSERT(a_going_powered, !out_valid_ff || going_ok, "going state without motor power")
   // rest states have the motor off
   `BMTC_ASSERT(a_rest_unpowered, !out_valid_ff || rest_ok, "rest state with motor power")
   // the first processed beat clears the first step flag
   `BMTC_ASSERT_NEXT(a_first_cleared, advance, !state_ff.first_step && out_valid_ff, "step lost")

endmodule

/* tb/sv/bmtc_checker.sv */
// beat checker for the blind motor travel controller: predicts and compares every result beat
`timescale 1ns / 1ps

module bmtc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_up_button,
   input  logic        req_down_button,
   input  logic        req_second_tick,
   input  logic [2:0]  req_remote_state,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_relay_common,
   input  logic        rsp_relay_direction,
   input  logic [2:0]  rsp_motion_state,
   input  logic        rsp_report_write,
   input  logic [2:0]  rsp_report_value,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   output int unsigned mismatch_count,
   output int unsigned beats_outstanding
);
   import bmtc_pkg::*;

   cfg_type              blind_cfg;
   motion_type           motion_now;
   logic [2:0]           status_now;
   logic                 first_poll;
   logic                 up_last;
   logic                 down_last;
   logic [TimeWidth-1:0] run_seconds;
   logic                 relay_on;
   logic                 relay_dir;
   result_type           relay_report_q[$];

   initial begin
      mismatch_count    = 0;
      beats_outstanding = 0;
   end

   // one poll step of the controller, returns the beat it produces
   function automatic result_type step_blind_motor(input item_type poll);
      logic       up_hit;
      logic       down_hit;
      logic       differs;
      logic       cmd_down;
      logic       cmd_up;
      logic       cmd_stop;
      result_type beat;
      up_hit   = poll.up_button && !up_last;
      down_hit = poll.down_button && !down_last;
      differs  = status_now != poll.remote_state;
      cmd_down = differs && poll.remote_state == RS_DOWN;
      cmd_up   = differs && poll.remote_state == RS_UP;
      cmd_stop = differs && poll.remote_state == RS_STOP;
      beat     = '0;

      if (poll.second_tick && run_seconds != TimeMax)
         run_seconds = run_seconds + 1'b1;

      if (first_poll) begin
         beat.report_write = 1'b1;
         beat.report_value = status_now;
         first_poll        = 1'b0;
      end

      case (motion_now)
         ST_STOP: begin
            relay_on          = 1'b0;
            relay_dir         = 1'b0;
            status_now        = RS_STOP;
            beat.report_write = 1'b1;
            beat.report_value = RS_STOP;
            motion_now        = ST_PAUSED;
         end
         ST_PAUSED: begin
            if (down_hit) begin
               motion_now        = ST_START_DOWN;
               status_now        = RS_DOWN;
               beat.report_write = 1'b1;
               beat.report_value = RS_DOWN;
            end
            if (up_hit) begin
               motion_now        = ST_START_UP;
               status_now        = RS_UP;
               beat.report_write = 1'b1;
               beat.report_value = RS_UP;
            end
            // remote start decides the state but writes no status here
            if (!blind_cfg.modbus_enabled) begin
               if (cmd_down) begin
                  motion_now = ST_START_DOWN;
                  status_now = RS_DOWN;
               end
               if (cmd_up) begin
                  motion_now = ST_START_UP;
                  status_now = RS_UP;
               end
            end
         end
         ST_START_DOWN: begin
            relay_on    = 1'b1;
            relay_dir   = !blind_cfg.invert_direction;
            run_seconds = '0;
            status_now  = RS_DOWN;
            if (!blind_cfg.modbus_enabled) begin
               beat.report_write = 1'b1;
               beat.report_value = RS_DOWN;
            end
            motion_now = ST_GOING_DOWN;
         end
         ST_GOING_DOWN: begin
            if (down_hit || up_hit || cmd_stop)
               motion_now = ST_STOP;
            if (run_seconds >= blind_cfg.travel_time_sec) begin
               relay_on          = 1'b0;
               relay_dir         = 1'b0;
               status_now        = RS_CLOSED;
               beat.report_write = 1'b1;
               beat.report_value = RS_CLOSED;
               motion_now        = ST_CLOSED;
            end
         end
         ST_CLOSED: begin
            if (up_hit || cmd_up)
               motion_now = ST_START_UP;
         end
         ST_START_UP: begin
            relay_on    = 1'b1;
            relay_dir   = blind_cfg.invert_direction;
            run_seconds = '0;
            status_now  = RS_UP;
            if (!blind_cfg.modbus_enabled) begin
               beat.report_write = 1'b1;
               beat.report_value = RS_UP;
            end
            motion_now = ST_GOING_UP;
         end
         ST_GOING_UP: begin
            if (down_hit || up_hit || cmd_stop)
               motion_now = ST_STOP;
            if (run_seconds >= blind_cfg.travel_time_sec) begin
               relay_on          = 1'b0;
               relay_dir         = 1'b0;
               status_now        = RS_OPEN;
               beat.report_write = 1'b1;
               beat.report_value = RS_OPEN;
               motion_now        = ST_OPEN;
            end
         end
         default: begin
            // open
            if (down_hit || cmd_down)
               motion_now = ST_START_DOWN;
         end
      endcase

      up_last              = poll.up_button;
      down_last            = poll.down_button;
      beat.relay_common    = relay_on;
      beat.relay_direction = relay_dir;
      beat.motion_state    = motion_now;
      return beat;
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      item_type   poll;
      result_type want;
      if (reset) begin
         blind_cfg   = '{travel_time_sec: TravelTimeReset, invert_direction: 1'b0,
                         modbus_enabled: 1'b0};
         motion_now  = ST_STOP;
         status_now  = RS_STOP;
         first_poll  = 1'b1;
         up_last     = 1'b0;
         down_last   = 1'b0;
         run_seconds = '0;
         relay_on    = 1'b0;
         relay_dir   = 1'b0;
         relay_report_q.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_TRAVEL_TIME: blind_cfg.travel_time_sec  = csr_data;
               CSR_INVERT_DIR:  blind_cfg.invert_direction = csr_data[0];
               CSR_MODBUS:      blind_cfg.modbus_enabled   = csr_data[0];
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            if (relay_report_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result beat with nothing expected (motion %0d write %0d)",
                           $time, rsp_motion_state, rsp_report_write);
            end else begin
               want = relay_report_q.pop_front();
               check_field("relay_common", want.relay_common, rsp_relay_common);
               check_field("relay_direction", want.relay_direction, rsp_relay_direction);
               check_field("motion_state", want.motion_state, rsp_motion_state);
               check_field("report_write", want.report_write, rsp_report_write);
               check_field("report_value", want.report_value, rsp_report_value);
            end
         end

         if (req_valid && !req_stall) begin
            poll.up_button    = req_up_button;
            poll.down_button  = req_down_button;
            poll.second_tick  = req_second_tick;
            poll.remote_state = req_remote_state;
            relay_report_q.push_back(step_blind_motor(poll));
         end
      end
      beats_outstanding <= relay_report_q.size();
   end

endmodule

/* tb/sv/tb_blind_motor_travel_controller.sv */
// top of the blind motor travel controller testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_blind_motor_travel_controller;
   import bmtc_pkg::*;

   // remote values outside the command set
   localparam logic [2:0] RemoteBogusLow  = 3'd5;
   localparam logic [2:0] RemoteBogusHigh = 3'd7;

   // travel time of the long uninterrupted run
   localparam logic [15:0] LongTravel = 16'd200;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_up_button;
   logic        req_down_button;
   logic        req_second_tick;
   logic [2:0]  req_remote_state;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_relay_common;
   logic        rsp_relay_direction;
   logic [2:0]  rsp_motion_state;
   logic        rsp_report_write;
   logic [2:0]  rsp_report_value;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   int unsigned mismatch_count;
   int unsigned beats_outstanding;

   // knobs shared between the stimulus and the stall generator
   bit          sender_calm;
   bit          rsp_free;
   int unsigned press_pct;
   int unsigned tick_pct;
   logic [2:0]  remote_hold;

   blind_motor_travel_controller i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_up_button       (req_up_button),
      .req_down_button     (req_down_button),
      .req_second_tick     (req_second_tick),
      .req_remote_state    (req_remote_state),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_relay_common    (rsp_relay_common),
      .rsp_relay_direction (rsp_relay_direction),
      .rsp_motion_state    (rsp_motion_state),
      .rsp_report_write    (rsp_report_write),
      .rsp_report_value    (rsp_report_value),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   bmtc_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_up_button       (req_up_button),
      .req_down_button     (req_down_button),
      .req_second_tick     (req_second_tick),
      .req_remote_state    (req_remote_state),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_relay_common    (rsp_relay_common),
      .rsp_relay_direction (rsp_relay_direction),
      .rsp_motion_state    (rsp_motion_state),
      .rsp_report_write    (rsp_report_write),
      .rsp_report_value    (rsp_report_value),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .mismatch_count      (mismatch_count),
      .beats_outstanding   (beats_outstanding)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // hard stop well beyond the slowest legal run
   initial begin : watchdog
      #50ms;
      $display("tb_blind_motor_travel_controller NOT OK");
      $finish;
   end

   // result side back-pressure: mostly short stalls, a few long ones,
   // and free-running stretches; fully released during the long travel run
   initial begin : rsp_stall_gen
      int unsigned run_len;
      int unsigned roll;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         roll = $urandom_range(0, 99);
         if (rsp_free || roll < 60) begin
            rsp_stall <= 1'b0;
            run_len = (roll < 8) ? $urandom_range(50, 150) : $urandom_range(1, 6);
         end else begin
            rsp_stall <= 1'b1;
            run_len = (roll < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
         end
         repeat (run_len - 1) @(negedge clock);
      end
   end

   // idle cycles ahead of a poll beat: mostly none or short, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (sender_calm || roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 2);
      if (roll < 97)
         return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   // entered and left just after a falling edge; valid stays high on exit
   // so back-to-back beats never drop valid within one step
   task automatic send_poll(input logic up, input logic down, input logic tick,
                            input logic [2:0] remote);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_up_button    <= up;
      req_down_button  <= down;
      req_second_tick  <= tick;
      req_remote_state <= remote;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // hold off the sender until every predicted beat has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (beats_outstanding != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // write all three registers while the block is idle;
   // the one-bit registers get junk in the unused upper bits
   task automatic load_settings(input logic [15:0] travel, input logic invert,
                                input logic modbus);
      logic [15:0] junk;
      settle();
      junk = 16'($urandom);
      csr_write <= 1'b1;
      csr_index <= CSR_TRAVEL_TIME;
      csr_data  <= travel;
      @(negedge clock);
      csr_index <= CSR_INVERT_DIR;
      csr_data  <= {junk[14:0], invert};
      @(negedge clock);
      csr_index <= CSR_MODBUS;
      csr_data  <= {junk[15:1], modbus};
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // random poll beat; remote value tends to persist like a real command register
   task automatic random_poll();
      logic up;
      logic down;
      logic tick;
      up   = $urandom_range(0, 99) < press_pct;
      down = $urandom_range(0, 99) < press_pct;
      tick = $urandom_range(0, 99) < tick_pct;
      if ($urandom_range(0, 99) < 20)
         remote_hold = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
      send_poll(up, down, tick, remote_hold);
   endtask

   initial begin : stimulus
      int unsigned phase;
      int unsigned roll;
      logic [15:0] travel;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_up_button    = 1'b0;
      req_down_button  = 1'b0;
      req_second_tick  = 1'b0;
      req_remote_state = RS_STOP;
      csr_write        = 1'b0;
      csr_index        = CSR_TRAVEL_TIME;
      csr_data         = '0;
      sender_calm      = 1'b0;
      rsp_free         = 1'b0;
      press_pct        = 10;
      tick_pct         = 50;
      remote_hold      = RS_STOP;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: 30 s travel, no invert, no modbus
      send_poll(1'b0, 1'b0, 1'b0, RS_STOP);         // first step writes status back
      send_poll(1'b0, 1'b1, 1'b0, RS_STOP);         // down edge starts down travel
      send_poll(1'b0, 1'b1, 1'b1, RS_DOWN);         // start clears the tick just counted
      send_poll(1'b1, 1'b0, 1'b1, RS_DOWN);         // up edge while going down stops
      send_poll(1'b1, 1'b0, 1'b0, RS_STOP);
      send_poll(1'b0, 1'b0, 1'b0, RS_UP);           // remote up start from paused
      send_poll(1'b0, 1'b0, 1'b1, RS_UP);
      send_poll(1'b0, 1'b0, 1'b0, RemoteBogusHigh); // no command, keeps going
      send_poll(1'b0, 1'b0, 1'b0, RS_STOP);         // remote stop differs from up
      send_poll(1'b0, 1'b0, 1'b0, RS_STOP);
      send_poll(1'b1, 1'b1, 1'b0, RS_DOWN);         // both buttons plus remote down
      send_poll(1'b0, 1'b0, 1'b0, RS_DOWN);
      send_poll(1'b0, 1'b0, 1'b0, RS_OPEN);
      send_poll(1'b0, 1'b0, 1'b0, RS_CLOSED);
      send_poll(1'b0, 1'b0, 1'b0, RS_STOP);
      send_poll(1'b0, 1'b0, 1'b0, RS_STOP);

      // zero travel time, inverted relay, modbus on
      load_settings(16'd0, 1'b1, 1'b1);
      send_poll(1'b0, 1'b0, 1'b0, RS_UP);           // remote start ignored under modbus
      send_poll(1'b0, 1'b1, 1'b0, RS_UP);           // button still starts
      send_poll(1'b0, 1'b0, 1'b0, RS_STOP);         // start report suppressed
      send_poll(1'b0, 1'b0, 1'b0, RS_STOP);         // timeout beats the remote stop
      send_poll(1'b1, 1'b0, 1'b1, RS_UP);
      send_poll(1'b0, 1'b0, 1'b0, RS_UP);
      send_poll(1'b1, 1'b0, 1'b1, RS_STOP);         // timeout beats the button stop
      send_poll(1'b0, 1'b1, 1'b0, RemoteBogusLow);

      // long travel time: run the full count down to the closed limit
      load_settings(LongTravel, 1'b0, 1'b0);
      send_poll(1'b0, 1'b0, 1'b1, RS_DOWN);
      sender_calm = 1'b1;
      rsp_free    = 1'b1;
      repeat (int'(LongTravel) + 4) send_poll(1'b0, 1'b0, 1'b1, RS_DOWN);
      send_poll(1'b1, 1'b0, 1'b0, RS_UP);
      sender_calm = 1'b0;
      rsp_free    = 1'b0;

      // random phases, each with its own settings and traffic mix
      for (phase = 0; phase < 8; phase++) begin
         roll = $urandom_range(0, 99);
         if (roll < 15)
            travel = 16'd0;
         else if (roll < 22)
            travel = TimeMax;
         else if (roll < 80)
            travel = 16'($urandom_range(1, 6));
         else
            travel = 16'($urandom_range(7, 40));
         load_settings(travel, 1'($urandom_range(0, 1)), ($urandom_range(0, 9) < 3));
         press_pct   = $urandom_range(5, 35);
         tick_pct    = $urandom_range(20, 100);
         sender_calm = ($urandom_range(0, 4) == 0);
         repeat (250) random_poll();
      end
      sender_calm = 1'b0;

      // drain, then allow for the pipeline and any stray beat
      settle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && beats_outstanding == 0)
         $display("tb_blind_motor_travel_controller OK");
      else
         $display("tb_blind_motor_travel_controller NOT OK");
      $finish;
   end

endmodule
